### rtl/lkv_pkg.sv
`timescale 1ns / 1ps

package lkv_pkg;

  localparam int DefaultEntries = 16;
  localparam int DefaultKeyBits = 32;

  localparam int CapWidth   = 5;
  localparam int ReqWidth   = 2;
  localparam int KeyInWidth = 32;
  localparam int DataWidth  = 32;

  localparam logic [CapWidth-1:0]  CapReset  = 5'd16;
  localparam logic [DataWidth-1:0] MissValue = 32'hFFFF_FFFF;

  localparam logic [ReqWidth-1:0] ReqInsert = 2'd0;
  localparam logic [ReqWidth-1:0] ReqGet    = 2'd1;
  localparam logic [ReqWidth-1:0] ReqPeek   = 2'd2;

  typedef struct packed {
    logic load_req;
    logic execute;
    logic load_out;
  } dp_cmd_t;

endpackage

### rtl/lru_key_value_cache.sv
// Pipeline: the request register loads on accept; the key match, recency update and value
// read happen in the match state and the output register loads in the finish state, which
// overlaps the next accept; an output stall holds the finish state and the next accept.
// Reset: asynchronous, active low; empties the store and sets capacity to 16.
// The store is usable in the first cycle after reset release.
`timescale 1ns / 1ps

module lru_key_value_cache import lkv_pkg::*; #(
  parameter int ENTRIES  = DefaultEntries,
  parameter int KEY_BITS = DefaultKeyBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CapWidth-1:0]   cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [63:0]           s_axis_tdata_i,  // lookup_key[31:0], write_value[63:32]
  input  logic [ReqWidth-1:0]   s_axis_tuser_i,  // req_type[1:0]
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [DataWidth-1:0]  m_axis_tdata_o,  // read_value[31:0]
  output logic                  m_axis_tuser_o   // found[0]
);

  dp_cmd_t cmd;

  lkv_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cmd_o           (cmd)
  );

  lkv_datapath #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_type_i    (s_axis_tuser_i),
    .lookup_key_i  (s_axis_tdata_i[31:0]),
    .write_value_i (s_axis_tdata_i[63:32]),
    .found_o       (m_axis_tuser_o),
    .read_value_o  (m_axis_tdata_o)
  );

endmodule

### rtl/lkv_ctrl.sv
`timescale 1ns / 1ps

module lkv_ctrl import lkv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_axis_tvalid_i,
  output logic    s_axis_tready_o,
  output logic    m_axis_tvalid_o,
  input  logic    m_axis_tready_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StMatch,
    StFinish
  } state_e;

  state_e state_q;
  logic   m_tvalid_q;
  logic   out_free;
  logic   accept;

  assign out_free        = !m_tvalid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == StIdle) || ((state_q == StFinish) && out_free);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = m_tvalid_q;

  assign cmd_o.load_req = accept;
  assign cmd_o.execute  = (state_q == StMatch);
  assign cmd_o.load_out = (state_q == StFinish) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      m_tvalid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (accept) state_q <= StMatch;
        end
        StMatch: begin
          state_q <= StFinish;
        end
        StFinish: begin
          if (out_free) state_q <= accept ? StMatch : StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
      if (cmd_o.load_out) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

endmodule

### rtl/lkv_datapath.sv
`timescale 1ns / 1ps

module lkv_datapath import lkv_pkg::*; #(
  parameter int ENTRIES  = DefaultEntries,
  parameter int KEY_BITS = DefaultKeyBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  input  logic                  cfg_we_i,
  input  logic [CapWidth-1:0]   cfg_wdata_i,
  input  logic [ReqWidth-1:0]   req_type_i,
  input  logic [KeyInWidth-1:0] lookup_key_i,
  input  logic [DataWidth-1:0]  write_value_i,
  output logic                  found_o,
  output logic [DataWidth-1:0]  read_value_o
);

  localparam int IdxW = $clog2(ENTRIES);
  localparam int CntW = $clog2(ENTRIES + 1);
  localparam int CmpW = (CntW > CapWidth) ? CntW : CapWidth;

  logic [CapWidth-1:0]  cap_q;
  logic [CntW-1:0]      count_q;
  logic [ENTRIES-1:0]   valid_q;
  logic [IdxW-1:0]      rank_q [ENTRIES];
  logic [KEY_BITS-1:0]  key_q  [ENTRIES];
  logic [DataWidth-1:0] value_mem [ENTRIES];
  logic [DataWidth-1:0] rdata_q;

  logic [ReqWidth-1:0]  req_type_q;
  logic [KEY_BITS-1:0]  req_key_q;
  logic [DataWidth-1:0] req_val_q;
  logic                 found_q;
  logic                 use_mem_q;
  logic                 found_out_q;
  logic [DataWidth-1:0] value_out_q;

  logic [CmpW-1:0]    cap_ext;
  logic [CntW-1:0]    eff_cap;
  logic               full;
  logic [IdxW-1:0]    last_rank;
  logic [ENTRIES-1:0] hit_vec, victim_vec, mru_vec;
  logic [IdxW-1:0]    hit_idx, victim_idx, free_idx, mru_idx;
  logic               hit, any_mru;
  logic               is_ins, is_get, is_peek;
  logic [IdxW-1:0]    ins_slot, touch_slot;
  logic [CntW-1:0]    touch_r;
  logic               do_touch, new_entry, key_we, mem_re;
  logic               found_d, use_mem_d;

  assign cap_ext   = CmpW'(cap_q);
  assign last_rank = IdxW'(count_q - CntW'(1));

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CntW'(1);
    end else if (cap_ext > CmpW'(ENTRIES)) begin
      eff_cap = CntW'(ENTRIES);
    end else begin
      eff_cap = CntW'(cap_ext);
    end
  end

  assign full = (count_q >= eff_cap);

  always_comb begin
    hit_idx    = '0;
    victim_idx = '0;
    free_idx   = '0;
    mru_idx    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]    = valid_q[i] && (key_q[i] == req_key_q);
      victim_vec[i] = valid_q[i] && (rank_q[i] == last_rank);
      mru_vec[i]    = valid_q[i] && (rank_q[i] == '0);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i])    hit_idx    = IdxW'(i);
      if (victim_vec[i]) victim_idx = IdxW'(i);
      if (mru_vec[i])    mru_idx    = IdxW'(i);
      if (!valid_q[i])   free_idx   = IdxW'(i);
    end
  end

  assign hit     = |hit_vec;
  assign any_mru = |mru_vec;
  assign is_ins  = (req_type_q == ReqInsert);
  assign is_get  = (req_type_q == ReqGet);
  assign is_peek = (req_type_q == ReqPeek);

  always_comb begin
    if (hit) begin
      ins_slot = hit_idx;
      touch_r  = CntW'(rank_q[hit_idx]);
    end else if (full) begin
      ins_slot = victim_idx;
      touch_r  = CntW'(last_rank);
    end else begin
      ins_slot = free_idx;
      touch_r  = count_q;
    end
    if (!is_ins) touch_r = CntW'(rank_q[hit_idx]);
  end

  assign touch_slot = is_ins ? ins_slot : hit_idx;
  assign do_touch   = cmd_i.execute && (is_ins || (is_get && hit));
  assign new_entry  = cmd_i.execute && is_ins && !hit && !full;
  assign key_we     = cmd_i.execute && is_ins && !hit;
  assign mem_re     = cmd_i.execute && !is_ins;
  assign found_d    = (is_ins && hit) || (is_get && hit) || (is_peek && any_mru);
  assign use_mem_d  = (is_get && hit) || (is_peek && any_mru);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CapReset;
      count_q <= '0;
      valid_q <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (new_entry) begin
        count_q           <= count_q + CntW'(1);
        valid_q[free_idx] <= 1'b1;
      end
      if (do_touch) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_q[i] && (CntW'(rank_q[i]) < touch_r)) rank_q[i] <= rank_q[i] + IdxW'(1);
        end
        rank_q[touch_slot] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) key_q[ins_slot] <= req_key_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && is_ins) value_mem[ins_slot] <= req_val_q;
    if (mem_re) rdata_q <= value_mem[is_get ? hit_idx : mru_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_type_q <= req_type_i;
      req_key_q  <= KEY_BITS'(lookup_key_i);
      req_val_q  <= write_value_i;
    end
    if (cmd_i.execute) begin
      found_q   <= found_d;
      use_mem_q <= use_mem_d;
    end
    if (cmd_i.load_out) begin
      found_out_q <= found_q;
      if (use_mem_q) begin
        value_out_q <= rdata_q;
      end else if (req_type_q == ReqInsert) begin
        value_out_q <= req_val_q;
      end else begin
        value_out_q <= MissValue;
      end
    end
  end

  assign found_o      = found_out_q;
  assign read_value_o = value_out_q;

endmodule

### bench/lru_cache_checker.sv
`timescale 1ns / 1ps

module lru_cache_checker import lkv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CapWidth-1:0]  cfg_wdata_i,
  input  logic                 req_tvalid_i,
  input  logic                 req_tready_i,
  input  logic [63:0]          req_tdata_i,
  input  logic [ReqWidth-1:0]  req_tuser_i,
  input  logic                 rsp_tvalid_i,
  input  logic                 rsp_tready_i,
  input  logic [DataWidth-1:0] rsp_tdata_i,
  input  logic                 rsp_tuser_i,
  output int                   fail_count_o,
  output int                   outstanding_o
);

  localparam int Entries = DefaultEntries;

  typedef struct packed {
    logic                 found;
    logic [DataWidth-1:0] value;
  } cache_response_t;

  logic [KeyInWidth-1:0] slot_key   [Entries];
  logic [DataWidth-1:0]  slot_value [Entries];
  logic                  slot_valid [Entries];
  logic [3:0]            slot_rank  [Entries];
  int unsigned           held;
  logic [CapWidth-1:0]   capacity;

  cache_response_t expected_responses[$];

  function automatic void promote(int s);
    logic [3:0] r;
    r = slot_rank[s];
    for (int i = 0; i < Entries; i++) begin
      if (slot_valid[i] && slot_rank[i] < r) slot_rank[i]++;
    end
    slot_rank[s] = '0;
  endfunction

  function automatic cache_response_t predict_response(logic [ReqWidth-1:0] req,
                                                       logic [KeyInWidth-1:0] key,
                                                       logic [DataWidth-1:0] value);
    cache_response_t resp;
    int hit;
    int victim;
    int free_slot;
    int unsigned limit;
    resp.found = 1'b0;
    resp.value = MissValue;
    hit = -1;
    for (int i = 0; i < Entries && hit < 0; i++) begin
      if (slot_valid[i] && slot_key[i] == key) hit = i;
    end
    if (capacity == 0) limit = 1;
    else if (capacity > Entries) limit = Entries;
    else limit = capacity;
    case (req)
      ReqInsert: begin
        if (hit >= 0) begin
          resp.found = 1'b1;
          slot_value[hit] = value;
          promote(hit);
        end else if (held >= limit) begin
          victim = -1;
          for (int i = 0; i < Entries; i++) begin
            if (slot_valid[i] && (victim < 0 || slot_rank[i] >= slot_rank[victim])) victim = i;
          end
          if (victim >= 0) begin
            slot_key[victim] = key;
            slot_value[victim] = value;
            promote(victim);
          end
        end else begin
          free_slot = -1;
          for (int i = 0; i < Entries && free_slot < 0; i++) begin
            if (!slot_valid[i]) free_slot = i;
          end
          if (free_slot >= 0) begin
            for (int i = 0; i < Entries; i++) begin
              if (slot_valid[i]) slot_rank[i]++;
            end
            slot_valid[free_slot] = 1'b1;
            slot_key[free_slot] = key;
            slot_value[free_slot] = value;
            slot_rank[free_slot] = '0;
            held++;
          end
        end
        resp.value = value;
      end
      ReqGet: begin
        if (hit >= 0) begin
          resp.found = 1'b1;
          resp.value = slot_value[hit];
          promote(hit);
        end
      end
      ReqPeek: begin
        for (int i = 0; i < Entries && !resp.found; i++) begin
          if (slot_valid[i] && slot_rank[i] == 0) begin
            resp.found = 1'b1;
            resp.value = slot_value[i];
          end
        end
      end
      default: begin
      end
    endcase
    return resp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cache_response_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) begin
        slot_key[i] = '0;
        slot_value[i] = '0;
        slot_valid[i] = 1'b0;
        slot_rank[i] = '0;
      end
      held = 0;
      capacity = CapReset;
      expected_responses.delete();
      outstanding_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) capacity = cfg_wdata_i;
      if (rsp_tvalid_i && rsp_tready_i) begin
        if (expected_responses.size() == 0) begin
          $display("%0t: response with none expected: expected none, actual found=%0b value=%h",
                   $time, rsp_tuser_i, rsp_tdata_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_responses.pop_front();
          if (want.found !== rsp_tuser_i || want.value !== rsp_tdata_i) begin
            $display("%0t: response mismatch: expected found=%0b value=%h, actual found=%0b value=%h",
                     $time, want.found, want.value, rsp_tuser_i, rsp_tdata_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (req_tvalid_i && req_tready_i) begin
        expected_responses.push_back(predict_response(req_tuser_i, req_tdata_i[31:0],
                                                      req_tdata_i[63:32]));
      end
      outstanding_o <= expected_responses.size();
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lkv_pkg::*;

  localparam logic [ReqWidth-1:0] ReqUnused = 2'd3;
  localparam int Phases = 14;
  localparam int RequestsPerPhase = 110;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CapWidth-1:0]  cfg_wdata_i = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [63:0]          s_axis_tdata_i = '0;
  logic [ReqWidth-1:0]  s_axis_tuser_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [DataWidth-1:0] m_axis_tdata_o;
  logic                 m_axis_tuser_o;

  int fail_count;
  int outstanding;
  logic steady = 1'b0;
  int rx_hold = 0;

  logic [CapWidth-1:0] phase_capacity [Phases] = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd0, 5'd16, 5'd3,
                                                   5'd20, 5'd2, 5'd9, 5'd16, 5'd7, 5'd1, 5'd16};
  logic [KeyInWidth-1:0] key_pool [24];

  always #2 clk_i = ~clk_i;

  lru_key_value_cache DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

  lru_cache_checker u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .req_tvalid_i  (s_axis_tvalid_i),
    .req_tready_i  (s_axis_tready_o),
    .req_tdata_i   (s_axis_tdata_i),
    .req_tuser_i   (s_axis_tuser_i),
    .rsp_tvalid_i  (m_axis_tvalid_o),
    .rsp_tready_i  (m_axis_tready_i),
    .rsp_tdata_i   (m_axis_tdata_o),
    .rsp_tuser_i   (m_axis_tuser_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (steady || sel < 60) return 0;
    if (sel < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // response side back-pressure
  always @(posedge clk_i) begin
    int sel;
    sel = $urandom_range(0, 99);
    if (rx_hold > 0) begin
      m_axis_tready_i <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (steady || sel < 70) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= 1'b0;
      rx_hold <= (sel < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
    end
  end

  task automatic send_request(input logic [ReqWidth-1:0] req, input logic [KeyInWidth-1:0] key,
                              input logic [DataWidth-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {value, key};
    s_axis_tuser_i <= req;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapWidth-1:0] cap);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_request();
    int sel;
    logic [ReqWidth-1:0] req;
    logic [KeyInWidth-1:0] key;
    logic [DataWidth-1:0] value;
    sel = $urandom_range(0, 99);
    if (sel < 45) req = ReqInsert;
    else if (sel < 80) req = ReqGet;
    else if (sel < 96) req = ReqPeek;
    else req = ReqUnused;
    key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 23)] : $urandom;
    value = $urandom;
    send_request(req, key, value);
  endtask

  initial begin
    int pool_size;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty store, then fill, update and look up
    send_request(ReqPeek, 32'h0, 32'h0);
    send_request(ReqGet, 32'hFFFF_FFFF, 32'h0);
    send_request(ReqUnused, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_request(ReqInsert, 32'h0, 32'h8000_0000);
    send_request(ReqInsert, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_request(ReqInsert, 32'h0, 32'hFFFF_FFFF);
    send_request(ReqGet, 32'hFFFF_FFFF, 32'h0);
    send_request(ReqGet, 32'h1234_5678, 32'h0);
    send_request(ReqPeek, 32'h0, 32'h0);
    send_request(ReqUnused, 32'h0, 32'h0);

    // capacity below current count
    write_capacity(5'd1);
    send_request(ReqInsert, 32'h5, 32'h0);
    send_request(ReqGet, 32'h0, 32'h0);
    send_request(ReqGet, 32'hFFFF_FFFF, 32'h0);
    send_request(ReqInsert, 32'h6, 32'h1);
    send_request(ReqPeek, 32'h0, 32'h0);

    // zero capacity acts as one, oversize saturates
    write_capacity(5'd0);
    send_request(ReqInsert, 32'h7, 32'h2);
    send_request(ReqPeek, 32'h0, 32'h0);
    write_capacity(5'd31);
    send_request(ReqInsert, 32'h8, 32'h3);
    send_request(ReqInsert, 32'h9, 32'h4);
    send_request(ReqGet, 32'h8, 32'h0);

    for (int p = 0; p < Phases; p++) begin
      write_capacity(phase_capacity[p]);
      steady <= (p % 4 == 3);
      pool_size = $urandom_range(2, 24);
      for (int i = 0; i < 24; i++) key_pool[i] = (i < pool_size) ? $urandom : key_pool[i % pool_size];
      for (int n = 0; n < RequestsPerPhase; n++) random_request();
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
